@@ rtl/fbso_pkg.sv @@
// Package for the fermion basis state operator: field widths, codes, payload types, helpers.
`default_nettype none

package fbso_pkg;

  // Field widths of one item and one result
  localparam int MODE_W   = 5;
  localparam int VALUE_W  = 32;
  localparam int CHARGE_W = 6;
  localparam int SIGN_W   = 2;
  localparam int OCC_W    = 32;
  localparam int COUNT_W  = 6;
  localparam int RANK_W   = 30;

  // Binomial coefficients up to C(32,16) fit in the rank width
  localparam int BINOM_W  = RANK_W;

  // Coefficient codes
  localparam logic signed [SIGN_W-1:0] SIGN_PLUS = 2'sb01;
  localparam logic signed [SIGN_W-1:0] SIGN_ZERO = 2'sb00;

  typedef enum logic [1:0] {
    CMD_LOAD_NUMBER = 2'd0,
    CMD_LOAD_RANK   = 2'd1,
    CMD_CREATE      = 2'd2,
    CMD_ANNIHILATE  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t                command;
    logic [MODE_W-1:0]   mode;
    logic [VALUE_W-1:0]  load_value;
    logic [CHARGE_W-1:0] load_charge;
  } item_t;

  typedef struct packed {
    logic signed [SIGN_W-1:0] sign;
    logic [OCC_W-1:0]         occupation;
    logic [COUNT_W-1:0]       occupied_count;
    logic [RANK_W-1:0]        sector_rank;
    logic                     bad_request;
  } result_t;

  // Flat index of C(n,k) in the Pascal triangle memory, one row of row_len entries per n
  function automatic int unsigned bin_index(input int unsigned n, input int unsigned k,
                                            input int unsigned row_len);
    return n * row_len + k;
  endfunction

endpackage

`default_nettype wire

@@ rtl/fbso_stream_if.sv @@
// Valid/ready stream interface carrying one payload per transaction.
`default_nettype none

interface fbso_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/fbso_ram.sv @@
// Generic RAM: one write port, two registered read ports.
`default_nettype none

module fbso_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 1089,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr_a,
  output logic      [WIDTH-1:0]  rd_data_a,
  input  wire logic [ADDR_W-1:0] rd_addr_b,
  output logic      [WIDTH-1:0]  rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read, read data registered
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

`default_nettype wire

@@ rtl/fbso_fill.sv @@
// Pascal triangle builder: writes C(n,k) for all k <= n <= N_MODES into the binomial RAM.
`default_nettype none

module fbso_fill
  import fbso_pkg::*;
#(
  parameter int N_MODES = 32
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic [BINOM_W-1:0]                    rd_data,
  output logic                                       busy,
  output logic [$clog2((N_MODES+1)*(N_MODES+1))-1:0] rd_addr,
  output logic                                       wr_en,
  output logic [$clog2((N_MODES+1)*(N_MODES+1))-1:0] wr_addr,
  output logic [BINOM_W-1:0]                         wr_data
);

  localparam int unsigned ROW_LEN = N_MODES + 1;
  localparam int ADDR_W = $clog2(ROW_LEN * ROW_LEN);
  localparam int IDX_W  = $clog2(N_MODES + 2);

  typedef enum logic [2:0] {
    FL_READ  = 3'b001,
    FL_WRITE = 3'b010,
    FL_DONE  = 3'b100
  } fill_state_t;

  fill_state_t        state;
  logic [IDX_W-1:0]   fn;
  logic [IDX_W-1:0]   fk;
  logic [BINOM_W-1:0] held;
  logic [BINOM_W-1:0] rd_part;
  logic               upper_valid;

  // C(n-1,k) exists only for k < n
  assign upper_valid = (fk < fn);
  assign rd_part     = upper_valid ? rd_data : '0;

  assign busy    = (state != FL_DONE);
  assign wr_en   = (state == FL_WRITE);
  assign rd_addr = upper_valid ?
                   ADDR_W'(bin_index(32'(fn - IDX_W'(1)), 32'(fk), ROW_LEN)) : '0;
  assign wr_addr = ADDR_W'(bin_index(32'(fn), 32'(fk), ROW_LEN));
  // Row zero is the single one; every other entry sums the two above it
  assign wr_data = (fn == '0) ? BINOM_W'(1) : rd_part + held;

  // Step through the triangle: read one entry of the row above, then write
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FL_READ;
      fn    <= '0;
      fk    <= '0;
      held  <= '0;
    end else begin
      unique case (state)
        FL_READ: begin
          state <= FL_WRITE;
        end
        FL_WRITE: begin
          if (fk == fn) begin
            held <= '0;
            fk   <= '0;
            if (fn == IDX_W'(N_MODES)) begin
              state <= FL_DONE;
            end else begin
              fn    <= fn + IDX_W'(1);
              state <= FL_READ;
            end
          end else begin
            held  <= rd_part;
            fk    <= fk + IDX_W'(1);
            state <= FL_READ;
          end
        end
        FL_DONE: begin
          state <= FL_DONE;
        end
        default: begin
          state <= FL_DONE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/fermion_basis_state_operator.sv @@
// Top level of the fermion basis state operator: state, bit-serial scans, result register.
//
//   channel  modport  payload   transaction
//   item     sink     item_t    command, mode, load_value, load_charge
//   result   source   result_t  sign, occupation, occupied_count, sector_rank, bad_request
//
// After reset the block builds Pascal's triangle in the binomial RAM, reading and then writing
// each entry; item.ready stays low meanwhile.
// Load number, create and annihilate run the rank scan: one mode bit per cycle, reading one
// binomial per cycle from the RAM. A rank load does a sector size lookup, then one mode bit
// per cycle of unranking (a refused load runs the rank scan instead).
// A result waits in its output register while the next item is taken; the block stalls
// only when it finishes an item and that register is still full.
`default_nettype none

module fermion_basis_state_operator
  import fbso_pkg::*;
#(
  parameter int N_MODES = 32
) (
  input wire logic       clk,
  input wire logic       rst,
  fbso_stream_if.sink    item,
  fbso_stream_if.source  result
);

  localparam int unsigned ROW_LEN = N_MODES + 1;
  localparam int DEPTH  = ROW_LEN * ROW_LEN;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int IDX_W  = $clog2(N_MODES + 2);

  typedef logic [N_MODES-1:0] mask_t;

  typedef enum logic [5:0] {
    ST_FILL   = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_THRESH = 6'b000100,
    ST_UNRANK = 6'b001000,
    ST_RANK   = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t                   state;
  mask_t                    mask;
  logic signed [SIGN_W-1:0] sign;
  logic                     flip;
  logic                     parity;
  logic                     bad;
  logic [MODE_W-1:0]        mode_reg;
  logic [VALUE_W-1:0]       value_reg;
  logic [CHARGE_W-1:0]      charge_reg;
  logic [IDX_W-1:0]         m;
  logic [IDX_W-1:0]         k;
  logic [IDX_W-1:0]         j;
  logic [IDX_W-1:0]         count;
  logic [BINOM_W-1:0]       rest;
  logic [BINOM_W-1:0]       rank_acc;
  logic                     sel;
  logic                     za;
  logic                     zb;
  logic                     rsp_valid;
  result_t                  rsp;

  logic                     fill_busy;
  logic [ADDR_W-1:0]        fill_rd_addr;
  logic                     fill_wr_en;
  logic [ADDR_W-1:0]        fill_wr_addr;
  logic [BINOM_W-1:0]       fill_wr_data;

  logic [ADDR_W-1:0]        rd_addr_a;
  logic [ADDR_W-1:0]        rd_addr_b;
  logic [BINOM_W-1:0]       rd_data_a;
  logic [BINOM_W-1:0]       rd_data_b;

  logic [IDX_W-1:0]         a_n;
  logic [IDX_W-1:0]         a_k;
  logic [IDX_W-1:0]         b_n;
  logic [IDX_W-1:0]         b_k;
  logic                     a_force_zero;

  logic                     accept;
  logic                     mode_ok;
  mask_t                    onehot;
  logic                     occ;
  logic [BINOM_W-1:0]       rd_a_val;
  logic [BINOM_W-1:0]       rd_b_val;
  logic [BINOM_W-1:0]       bin;
  logic                     thr_bad;
  logic                     unrank_set;
  logic [IDX_W-1:0]         k_dec;
  logic [IDX_W-1:0]         charge_idx;
  logic                     below;
  logic signed [SIGN_W-1:0] sign_final;

  // Address of C(n,k); entries with k > n are never stored, map to address zero and are zeroed by the za/zb tags
  function automatic logic [ADDR_W-1:0] read_addr(input logic [IDX_W-1:0] n,
                                                  input logic [IDX_W-1:0] kk);
    logic [ADDR_W-1:0] addr;
    addr = '0;
    if (kk <= n) begin
      addr = ADDR_W'(bin_index(32'(n), 32'(kk), ROW_LEN));
    end
    return addr;
  endfunction

  fbso_fill #(
    .N_MODES (N_MODES)
  ) u_fill (
    .clk     (clk),
    .rst     (rst),
    .rd_data (rd_data_a),
    .busy    (fill_busy),
    .rd_addr (fill_rd_addr),
    .wr_en   (fill_wr_en),
    .wr_addr (fill_wr_addr),
    .wr_data (fill_wr_data)
  );

  fbso_ram #(
    .WIDTH (BINOM_W),
    .DEPTH (DEPTH)
  ) u_binom_ram (
    .clk       (clk),
    .wr_en     (fill_wr_en),
    .wr_addr   (fill_wr_addr),
    .wr_data   (fill_wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_data_a (rd_data_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_b (rd_data_b)
  );

  // Handshakes
  assign item.ready     = (state == ST_IDLE);
  assign accept         = item.valid && item.ready;
  assign result.valid   = rsp_valid;
  assign result.payload = rsp;

  // Operator decode on the incoming item
  assign mode_ok = (7'(item.payload.mode) < 7'(N_MODES));
  assign onehot  = mask_t'(1) << item.payload.mode;
  assign occ     = |(mask & onehot);

  // Binomial picked from the two speculative reads
  assign rd_a_val = za ? '0 : rd_data_a;
  assign rd_b_val = zb ? '0 : rd_data_b;
  assign bin      = sel ? rd_b_val : rd_a_val;

  assign thr_bad    = za || (VALUE_W'(rd_a_val) <= value_reg);
  assign unrank_set = (k != '0) && (bin <= rest);
  assign k_dec      = (k == '0) ? '0 : k - IDX_W'(1);
  assign charge_idx = IDX_W'(charge_reg);
  assign below      = (7'(m) < 7'(mode_reg));
  assign sign_final = (flip && parity) ? -sign : sign;

  // Pick the next binomial reads: both outcomes of each scan bit are fetched; idle fetches a sector size
  always_comb begin
    a_n          = '0;
    a_k          = IDX_W'(1);
    b_n          = '0;
    b_k          = IDX_W'(2);
    a_force_zero = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (item.payload.command == CMD_LOAD_RANK) begin
          a_n          = IDX_W'(N_MODES);
          a_k          = IDX_W'(item.payload.load_charge);
          a_force_zero = (7'(item.payload.load_charge) > 7'(N_MODES));
        end
      end
      ST_THRESH: begin
        if (!thr_bad) begin
          a_n = IDX_W'(N_MODES - 1);
          a_k = charge_idx;
          b_n = IDX_W'(N_MODES - 1);
          b_k = (charge_idx == '0) ? '0 : charge_idx - IDX_W'(1);
        end
      end
      ST_UNRANK: begin
        a_n = m - IDX_W'(1);
        a_k = k;
        b_n = m - IDX_W'(1);
        b_k = k_dec;
      end
      ST_RANK: begin
        a_n = m + IDX_W'(1);
        a_k = j;
        b_n = m + IDX_W'(1);
        b_k = j + IDX_W'(1);
      end
      ST_FILL, ST_FINISH: begin
        a_n = '0;
      end
      default: begin
        a_n = '0;
      end
    endcase
  end

  assign rd_addr_a = (state == ST_FILL) ? fill_rd_addr : read_addr(a_n, a_k);
  assign rd_addr_b = read_addr(b_n, b_k);

  // Tag reads that fall outside the triangle
  always_ff @(posedge clk) begin
    za <= a_force_zero || (a_k > a_n);
    zb <= (b_k > b_n);
  end

  // Sequencer, state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_FILL;
      mask      <= '0;
      sign      <= SIGN_PLUS;
      flip      <= 1'b0;
      parity    <= 1'b0;
      bad       <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      // Raise the result flag when a result is written, drop it when taken
      if (state == ST_FINISH && (!rsp_valid || result.ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && result.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_FILL: begin
          if (!fill_busy) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            mode_reg   <= item.payload.mode;
            value_reg  <= item.payload.load_value;
            charge_reg <= item.payload.load_charge;
            m          <= '0;
            j          <= IDX_W'(1);
            sel        <= 1'b0;
            rank_acc   <= '0;
            count      <= '0;
            parity     <= 1'b0;
            bad        <= 1'b0;
            unique case (item.payload.command)
              CMD_LOAD_NUMBER: begin
                mask  <= mask_t'(item.payload.load_value);
                sign  <= SIGN_PLUS;
                state <= ST_RANK;
              end
              CMD_LOAD_RANK: begin
                state <= ST_THRESH;
              end
              CMD_CREATE, CMD_ANNIHILATE: begin
                state <= ST_RANK;
                if (sign != SIGN_ZERO && mode_ok) begin
                  // Create on an occupied mode or annihilate on an empty one kills the state
                  if ((item.payload.command == CMD_CREATE) == occ) begin
                    sign <= SIGN_ZERO;
                  end else begin
                    mask <= mask ^ onehot;
                    flip <= 1'b1;
                  end
                end
              end
              default: begin
                state <= ST_RANK;
              end
            endcase
          end
        end
        ST_THRESH: begin
          if (thr_bad) begin
            // Refuse the load and report the unchanged state
            bad   <= 1'b1;
            state <= ST_RANK;
          end else begin
            m     <= IDX_W'(N_MODES - 1);
            k     <= charge_idx;
            rest  <= BINOM_W'(value_reg);
            sel   <= 1'b0;
            state <= ST_UNRANK;
          end
        end
        ST_UNRANK: begin
          // Shift in one mode bit per cycle, highest mode first
          mask <= mask_t'({mask, unrank_set});
          sel  <= unrank_set;
          if (unrank_set) begin
            rest <= rest - bin;
            k    <= k - IDX_W'(1);
          end
          if (m == '0) begin
            sign     <= SIGN_PLUS;
            count    <= charge_idx;
            rank_acc <= BINOM_W'(value_reg);
            state    <= ST_FINISH;
          end else begin
            m <= m - IDX_W'(1);
          end
        end
        ST_RANK: begin
          // Rotate the mask one bit per cycle, lowest mode first
          mask   <= mask_t'({mask, mask} >> 1);
          sel    <= mask[0];
          parity <= parity ^ (mask[0] && below);
          if (mask[0]) begin
            rank_acc <= rank_acc + bin;
            count    <= count + IDX_W'(1);
            j        <= j + IDX_W'(1);
          end
          if (m == IDX_W'(N_MODES - 1)) begin
            state <= ST_FINISH;
          end else begin
            m <= m + IDX_W'(1);
          end
        end
        ST_FINISH: begin
          if (!rsp_valid || result.ready) begin
            rsp.sign           <= sign_final;
            rsp.occupation     <= OCC_W'(mask);
            rsp.occupied_count <= COUNT_W'(count);
            rsp.sector_rank    <= rank_acc;
            rsp.bad_request    <= bad;
            sign               <= sign_final;
            flip               <= 1'b0;
            state              <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // The coefficient never takes the unused code
  a_sign_code: assert property (@(posedge clk) disable iff (rst)
    sign != 2'sb10)
    else $error("sign register holds an invalid code");

  // A global load goes straight into the rank scan
  a_load_to_rank: assert property (@(posedge clk) disable iff (rst)
    (accept && item.payload.command == CMD_LOAD_NUMBER) |=> (state == ST_RANK))
    else $error("global load did not start the rank scan");

  // Unranking never has more modes left to place than positions left
  a_unrank_room: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UNRANK) |-> ((IDX_W+1)'(k) <= (IDX_W+1)'(m) + (IDX_W+1)'(1)))
    else $error("unranking ran out of positions");
`endif

endmodule

`default_nettype wire
